>>> hw/rtl/tmu_pkg.sv
`timescale 1ns / 1ps

package tmu_pkg;

   localparam int COORD_W      = 16;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int SUM_W        = COORD_W + 2;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int DOT_W        = PROD_W + 1;
   localparam int SQ_W         = PROD_W - 1;
   localparam int RAD_W        = SQ_W + 16;
   localparam int ROOT_W       = (RAD_W + 1) / 2;
   localparam int SIDE_SUM_W   = ROOT_W + 2;
   localparam int AREA_W       = 35;
   localparam int PERIM_W      = 19;
   localparam int ANGLE_W      = 16;
   localparam int ANGLE_FRAC   = 14;

   // normalization and cordic datapath
   localparam int NORM_TOP     = 40;
   localparam int NORM_STAGES  = 6;
   localparam int NRM_W        = NORM_TOP + 2;
   localparam int CORD_W       = NRM_W + 3;
   localparam int Z_W          = 34;
   localparam int CORDIC_STEPS = 30;
   localparam int ANG_SHIFT    = 30 - ANGLE_FRAC;

   localparam logic [Z_W-1:0] PI_HALF_Q30 = 34'd1686629713;
   localparam logic [Z_W-1:0] PI_Q30      = 34'd3373259426;
   localparam logic [Z_W-1:0] ANG_ROUND   = Z_W'(1) << (ANG_SHIFT - 1);
   localparam logic [ANGLE_W-1:0] ANGLE_RIGHT =
      ANGLE_W'((PI_HALF_Q30 + ANG_ROUND) >> ANG_SHIFT);

   // ceil(2^17 / 3), exact for magnitudes below 2^17
   localparam int CENT_SHIFT = 17;
   localparam int CENT_PROD_W = DIFF_W + CENT_SHIFT - 1;
   localparam logic [CENT_PROD_W-1:0] CENT_RECIP = CENT_PROD_W'(43691);

   // pipeline positions in the top level
   localparam int CORD_LAT  = 2 + NORM_STAGES + CORDIC_STEPS;
   localparam int ST_AREA   = 4;
   localparam int ST_PERIM  = 3 + ROOT_W + 1;
   localparam int LAT       = 3 + CORD_LAT;

   function automatic logic [Z_W-1:0] atan_q30(input int unsigned i);
      case (i)
         0: return 34'd843314857;
         1: return 34'd497837829;
         2: return 34'd263043837;
         3: return 34'd133525159;
         4: return 34'd67021687;
         5: return 34'd33543516;
         6: return 34'd16775851;
         7: return 34'd8388437;
         8: return 34'd4194283;
         9: return 34'd2097149;
         default: return (i < 31) ? (Z_W'(1) << (30 - i)) : '0;
      endcase
   endfunction

endpackage

>>> hw/rtl/tmu_sqrt.sv
`timescale 1ns / 1ps

module tmu_sqrt (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [tmu_pkg::RAD_W-1:0]   rad_i,
   output logic [tmu_pkg::ROOT_W-1:0]  root_o
);

   localparam int RW = tmu_pkg::RAD_W;
   localparam int QW = tmu_pkg::ROOT_W;
   localparam int TW = 2 * QW;

   logic [RW-1:0] rem_ff [1:QW];
   logic [QW-1:0] q_ff   [1:QW];
   logic [RW-1:0] rem_cur [0:QW-1];
   logic [QW-1:0] q_cur   [0:QW-1];

   assign rem_cur[0] = rad_i;
   assign q_cur[0]   = '0;

   for (genvar j = 0; j < QW; j++) begin : g_bit
      localparam int B = QW - 1 - j;
      logic [TW-1:0] trial;
      logic          take;

      if (j > 0) begin : g_link
         assign rem_cur[j] = rem_ff[j];
         assign q_cur[j]   = q_ff[j];
      end

      // (q + 2^b)^2 - q^2 = q * 2^(b+1) + 2^(2b)
      assign trial = (TW'(q_cur[j]) << (B + 1)) + (TW'(1) << (2 * B));
      assign take  = trial <= TW'(rem_cur[j]);

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= take ? RW'(TW'(rem_cur[j]) - trial) : rem_cur[j];
            q_ff[j+1]   <= take ? (q_cur[j] | (QW'(1) << B)) : q_cur[j];
         end
      end
   end

   assign root_o = q_ff[QW];

endmodule

>>> hw/rtl/tmu_cordic.sv
`timescale 1ns / 1ps

module tmu_cordic (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [tmu_pkg::DOT_W-1:0]   dot_i,
   input  logic signed [tmu_pkg::DOT_W-1:0]   crs_i,
   input  logic                               spec_i,
   output logic [tmu_pkg::ANGLE_W-1:0]        angle_o
);

   localparam int DW = tmu_pkg::DOT_W;
   localparam int NW = tmu_pkg::NRM_W;
   localparam int CW = tmu_pkg::CORD_W;
   localparam int ZW = tmu_pkg::Z_W;
   localparam int NS = tmu_pkg::NORM_STAGES;
   localparam int CS = tmu_pkg::CORDIC_STEPS;

   logic [DW-1:0]        cmag;
   logic [NW-1:0]        nx_ff [0:NS];
   logic [NW-1:0]        ny_ff [0:NS];
   logic signed [ZW-1:0] nz_ff [0:NS];
   logic                 spec_ff [0:NS+CS];
   logic signed [CW-1:0] cx_cur [0:CS];
   logic signed [CW-1:0] cy_cur [0:CS];
   logic signed [ZW-1:0] cz_cur [0:CS];
   logic signed [CW-1:0] cx_ff [1:CS];
   logic signed [CW-1:0] cy_ff [1:CS];
   logic signed [ZW-1:0] cz_ff [1:CS];
   logic signed [ZW-1:0] zc;
   logic [ZW-1:0]        zr;
   logic [tmu_pkg::ANGLE_W-1:0] angle_ff;

   assign cmag = crs_i[DW-1] ? DW'(-crs_i) : DW'(crs_i);

   // fold into the right half plane: y is the cross magnitude, or minus a negative dot with z preset to pi/2
   always_ff @(posedge clock) begin
      if (adv) begin
         spec_ff[0] <= spec_i;
         if (dot_i[DW-1]) begin
            nx_ff[0] <= NW'(cmag);
            ny_ff[0] <= NW'(DW'(-dot_i));
            nz_ff[0] <= $signed(tmu_pkg::PI_HALF_Q30);
         end else begin
            nx_ff[0] <= NW'(DW'(dot_i));
            ny_ff[0] <= NW'(cmag);
            nz_ff[0] <= '0;
         end
      end
   end

   // greedy binary shift search, one more doubling at the end
   for (genvar n = 0; n < NS; n++) begin : g_norm
      localparam int K = 32 >> n;
      localparam int EXTRA = (n == NS - 1) ? 1 : 0;
      logic [NW-1:0] orv;
      logic          hit;

      assign orv = nx_ff[n] | ny_ff[n];
      assign hit = (orv >> (tmu_pkg::NORM_TOP - K)) == '0;

      always_ff @(posedge clock) begin
         if (adv) begin
            nx_ff[n+1]   <= (hit ? (nx_ff[n] << K) : nx_ff[n]) << EXTRA;
            ny_ff[n+1]   <= (hit ? (ny_ff[n] << K) : ny_ff[n]) << EXTRA;
            nz_ff[n+1]   <= nz_ff[n];
            spec_ff[n+1] <= spec_ff[n];
         end
      end
   end

   assign cx_cur[0] = $signed(CW'(nx_ff[NS]));
   assign cy_cur[0] = $signed(CW'(ny_ff[NS]));
   assign cz_cur[0] = nz_ff[NS];

   for (genvar i = 0; i < CS; i++) begin : g_step
      logic signed [ZW-1:0] at;

      if (i > 0) begin : g_link
         assign cx_cur[i] = cx_ff[i];
         assign cy_cur[i] = cy_ff[i];
         assign cz_cur[i] = cz_ff[i];
      end

      assign at = $signed(tmu_pkg::atan_q30(i));

      always_ff @(posedge clock) begin
         if (adv) begin
            spec_ff[NS+i+1] <= spec_ff[NS+i];
            if (!cy_cur[i][CW-1]) begin
               cx_ff[i+1] <= cx_cur[i] + (cy_cur[i] >>> i);
               cy_ff[i+1] <= cy_cur[i] - (cx_cur[i] >>> i);
               cz_ff[i+1] <= cz_cur[i] + at;
            end else begin
               cx_ff[i+1] <= cx_cur[i] - (cy_cur[i] >>> i);
               cy_ff[i+1] <= cy_cur[i] + (cx_cur[i] >>> i);
               cz_ff[i+1] <= cz_cur[i] - at;
            end
         end
      end
   end

   always_comb begin
      if (cz_ff[CS][ZW-1]) begin
         zc = '0;
      end else if (cz_ff[CS] > $signed(tmu_pkg::PI_Q30)) begin
         zc = $signed(tmu_pkg::PI_Q30);
      end else begin
         zc = cz_ff[CS];
      end
      zr = ZW'(zc) + tmu_pkg::ANG_ROUND;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= spec_ff[NS+CS] ? tmu_pkg::ANGLE_RIGHT
                                    : zr[tmu_pkg::ANG_SHIFT +: tmu_pkg::ANGLE_W];
      end
   end

   assign angle_o = angle_ff;

endmodule

>>> hw/rtl/triangle_metrics_unit.sv
`timescale 1ns / 1ps
// channel     ports                           direction  moves
// request     req_valid/req_ready, req_a..c*  in         one triangle, three vertices
// response    rsp_valid/rsp_ready, rsp_*      out        area, perimeter, angles, centroid
//
// one triangle enters per cycle unless a held response stalls the pipeline; its result is valid in the last stage
// 41 register stages, set by the angle path: 3 front, fold, 6 normalize, 30 cordic, output
// reset clears only the valid bits of the pipeline
// a held response freezes every stage at once, so req_ready drops in that cycle

module triangle_metrics_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tmu_pkg::COORD_W-1:0]   req_ax,
   input  logic signed [tmu_pkg::COORD_W-1:0]   req_ay,
   input  logic signed [tmu_pkg::COORD_W-1:0]   req_bx,
   input  logic signed [tmu_pkg::COORD_W-1:0]   req_by,
   input  logic signed [tmu_pkg::COORD_W-1:0]   req_cx,
   input  logic signed [tmu_pkg::COORD_W-1:0]   req_cy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tmu_pkg::AREA_W-1:0]           rsp_area,
   output logic [tmu_pkg::PERIM_W-1:0]          rsp_perimeter,
   output logic [tmu_pkg::ANGLE_W-1:0]          rsp_angle_a,
   output logic [tmu_pkg::ANGLE_W-1:0]          rsp_angle_b,
   output logic [tmu_pkg::ANGLE_W-1:0]          rsp_angle_c,
   output logic signed [tmu_pkg::COORD_W-1:0]   rsp_centroid_x,
   output logic signed [tmu_pkg::COORD_W-1:0]   rsp_centroid_y
);

   localparam int DFW = tmu_pkg::DIFF_W;
   localparam int SMW = tmu_pkg::SUM_W;
   localparam int PW  = tmu_pkg::PROD_W;
   localparam int DW  = tmu_pkg::DOT_W;
   localparam int SQW = tmu_pkg::SQ_W;
   localparam int RW  = tmu_pkg::RAD_W;
   localparam int QW  = tmu_pkg::ROOT_W;
   localparam int CPW = tmu_pkg::CENT_PROD_W;
   localparam int CW  = tmu_pkg::COORD_W;
   localparam int LAT = tmu_pkg::LAT;

   logic            adv;
   logic [LAT:1]    vld_ff;

   // stage 1
   logic signed [DFW-1:0] abx_ff, aby_ff, bcx_ff, bcy_ff, acx_ff, acy_ff;
   logic signed [SMW-1:0] sumx_ff, sumy_ff;
   logic                  zab_ff, zbc_ff, zac_ff;

   // stage 2
   logic [SQW-1:0]        sqabx_ff, sqaby_ff, sqbcx_ff, sqbcy_ff, sqacx_ff, sqacy_ff;
   logic signed [PW-1:0]  da1_ff, da2_ff, ca1_ff, ca2_ff;
   logic signed [PW-1:0]  db1_ff, db2_ff, cb1_ff, cb2_ff;
   logic signed [PW-1:0]  dc1_ff, dc2_ff, cc1_ff, cc2_ff;
   logic                  spa2_ff, spb2_ff, spc2_ff;
   logic                  cxneg2_ff, cyneg2_ff;
   logic [DFW-1:0]        cxmag_ff, cymag_ff;

   // stage 3
   logic signed [DW-1:0]  dota_ff, crsa_ff, dotb_ff, crsb_ff, dotc_ff, crsc_ff;
   logic                  spa3_ff, spb3_ff, spc3_ff;
   logic [RW-1:0]         radab_ff, radbc_ff, radac_ff;
   logic                  cxneg3_ff, cyneg3_ff;
   logic [CPW-1:0]        cxprod_ff, cyprod_ff;

   // delay lines to the response register
   logic [DW-1:0]                   amag;
   logic [tmu_pkg::AREA_W-1:0]      area_ff [tmu_pkg::ST_AREA:LAT];
   logic signed [CW-1:0]            cenx_ff [tmu_pkg::ST_AREA:LAT];
   logic signed [CW-1:0]            ceny_ff [tmu_pkg::ST_AREA:LAT];
   logic [CW-1:0]                   qx, qy;
   logic [QW-1:0]                   side_ab, side_bc, side_ac;
   logic [tmu_pkg::SIDE_SUM_W-1:0]  side_sum;
   logic [tmu_pkg::PERIM_W-1:0]     perim_ff [tmu_pkg::ST_PERIM:LAT];

   assign adv       = ~vld_ff[LAT] | rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-1:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         abx_ff  <= DFW'(req_bx) - DFW'(req_ax);
         aby_ff  <= DFW'(req_by) - DFW'(req_ay);
         bcx_ff  <= DFW'(req_cx) - DFW'(req_bx);
         bcy_ff  <= DFW'(req_cy) - DFW'(req_by);
         acx_ff  <= DFW'(req_cx) - DFW'(req_ax);
         acy_ff  <= DFW'(req_cy) - DFW'(req_ay);
         sumx_ff <= SMW'(req_ax) + SMW'(req_bx) + SMW'(req_cx);
         sumy_ff <= SMW'(req_ay) + SMW'(req_by) + SMW'(req_cy);
         zab_ff  <= (req_ax == req_bx) && (req_ay == req_by);
         zbc_ff  <= (req_bx == req_cx) && (req_by == req_cy);
         zac_ff  <= (req_ax == req_cx) && (req_ay == req_cy);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqabx_ff  <= SQW'(PW'(abx_ff) * PW'(abx_ff));
         sqaby_ff  <= SQW'(PW'(aby_ff) * PW'(aby_ff));
         sqbcx_ff  <= SQW'(PW'(bcx_ff) * PW'(bcx_ff));
         sqbcy_ff  <= SQW'(PW'(bcy_ff) * PW'(bcy_ff));
         sqacx_ff  <= SQW'(PW'(acx_ff) * PW'(acx_ff));
         sqacy_ff  <= SQW'(PW'(acy_ff) * PW'(acy_ff));
         // angle at a: u = ab, v = ac
         da1_ff    <= abx_ff * acx_ff;
         da2_ff    <= aby_ff * acy_ff;
         ca1_ff    <= abx_ff * acy_ff;
         ca2_ff    <= aby_ff * acx_ff;
         // angle at b: u = bc, v = -ab
         db1_ff    <= bcx_ff * abx_ff;
         db2_ff    <= bcy_ff * aby_ff;
         cb1_ff    <= bcy_ff * abx_ff;
         cb2_ff    <= bcx_ff * aby_ff;
         // angle at c: u = -ac, v = -bc
         dc1_ff    <= acx_ff * bcx_ff;
         dc2_ff    <= acy_ff * bcy_ff;
         cc1_ff    <= acx_ff * bcy_ff;
         cc2_ff    <= acy_ff * bcx_ff;
         spa2_ff   <= zab_ff | zac_ff;
         spb2_ff   <= zbc_ff | zab_ff;
         spc2_ff   <= zac_ff | zbc_ff;
         cxneg2_ff <= sumx_ff[SMW-1];
         cyneg2_ff <= sumy_ff[SMW-1];
         cxmag_ff  <= sumx_ff[SMW-1] ? DFW'(-sumx_ff) : DFW'(sumx_ff);
         cymag_ff  <= sumy_ff[SMW-1] ? DFW'(-sumy_ff) : DFW'(sumy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dota_ff   <= DW'(da1_ff) + DW'(da2_ff);
         crsa_ff   <= DW'(ca1_ff) - DW'(ca2_ff);
         dotb_ff   <= -(DW'(db1_ff) + DW'(db2_ff));
         crsb_ff   <= DW'(cb1_ff) - DW'(cb2_ff);
         dotc_ff   <= DW'(dc1_ff) + DW'(dc2_ff);
         crsc_ff   <= DW'(cc1_ff) - DW'(cc2_ff);
         spa3_ff   <= spa2_ff;
         spb3_ff   <= spb2_ff;
         spc3_ff   <= spc2_ff;
         // squared length with 16 extra fraction bits for the root
         radab_ff  <= {SQW'(sqabx_ff + sqaby_ff), 16'd0};
         radbc_ff  <= {SQW'(sqbcx_ff + sqbcy_ff), 16'd0};
         radac_ff  <= {SQW'(sqacx_ff + sqacy_ff), 16'd0};
         cxneg3_ff <= cxneg2_ff;
         cyneg3_ff <= cyneg2_ff;
         cxprod_ff <= CPW'(cxmag_ff) * tmu_pkg::CENT_RECIP;
         cyprod_ff <= CPW'(cymag_ff) * tmu_pkg::CENT_RECIP;
      end
   end

   // the area cross product equals the angle-a cross product
   assign amag = crsa_ff[DW-1] ? DW'(-crsa_ff) : DW'(crsa_ff);
   assign qx   = cxprod_ff[tmu_pkg::CENT_SHIFT +: CW];
   assign qy   = cyprod_ff[tmu_pkg::CENT_SHIFT +: CW];

   always_ff @(posedge clock) begin
      if (adv) begin
         area_ff[tmu_pkg::ST_AREA] <= tmu_pkg::AREA_W'(amag >> 1);
         cenx_ff[tmu_pkg::ST_AREA] <= cxneg3_ff ? $signed(-qx) : $signed(qx);
         ceny_ff[tmu_pkg::ST_AREA] <= cyneg3_ff ? $signed(-qy) : $signed(qy);
         for (int i = tmu_pkg::ST_AREA + 1; i <= LAT; i++) begin
            area_ff[i] <= area_ff[i-1];
            cenx_ff[i] <= cenx_ff[i-1];
            ceny_ff[i] <= ceny_ff[i-1];
         end
      end
   end

   tmu_sqrt u_sqrt_ab (.clock(clock), .adv(adv), .rad_i(radab_ff), .root_o(side_ab));
   tmu_sqrt u_sqrt_bc (.clock(clock), .adv(adv), .rad_i(radbc_ff), .root_o(side_bc));
   tmu_sqrt u_sqrt_ac (.clock(clock), .adv(adv), .rad_i(radac_ff), .root_o(side_ac));

   assign side_sum = tmu_pkg::SIDE_SUM_W'(side_ab) + tmu_pkg::SIDE_SUM_W'(side_bc)
                   + tmu_pkg::SIDE_SUM_W'(side_ac);

   always_ff @(posedge clock) begin
      if (adv) begin
         perim_ff[tmu_pkg::ST_PERIM] <= side_sum[8 +: tmu_pkg::PERIM_W];
         for (int i = tmu_pkg::ST_PERIM + 1; i <= LAT; i++) begin
            perim_ff[i] <= perim_ff[i-1];
         end
      end
   end

   tmu_cordic u_ang_a (
      .clock(clock), .adv(adv), .dot_i(dota_ff), .crs_i(crsa_ff),
      .spec_i(spa3_ff), .angle_o(rsp_angle_a)
   );
   tmu_cordic u_ang_b (
      .clock(clock), .adv(adv), .dot_i(dotb_ff), .crs_i(crsb_ff),
      .spec_i(spb3_ff), .angle_o(rsp_angle_b)
   );
   tmu_cordic u_ang_c (
      .clock(clock), .adv(adv), .dot_i(dotc_ff), .crs_i(crsc_ff),
      .spec_i(spc3_ff), .angle_o(rsp_angle_c)
   );

   assign rsp_area       = area_ff[LAT];
   assign rsp_perimeter  = perim_ff[LAT];
   assign rsp_centroid_x = cenx_ff[LAT];
   assign rsp_centroid_y = ceny_ff[LAT];

endmodule

>>> hw/rtl/tmu_checker.sv
`timescale 1ns / 1ps

module tmu_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic signed [tmu_pkg::COORD_W-1:0]   req_ax,
   input logic signed [tmu_pkg::COORD_W-1:0]   req_ay,
   input logic signed [tmu_pkg::COORD_W-1:0]   req_bx,
   input logic signed [tmu_pkg::COORD_W-1:0]   req_by,
   input logic signed [tmu_pkg::COORD_W-1:0]   req_cx,
   input logic signed [tmu_pkg::COORD_W-1:0]   req_cy,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [tmu_pkg::AREA_W-1:0]           rsp_area,
   input logic [tmu_pkg::PERIM_W-1:0]          rsp_perimeter,
   input logic [tmu_pkg::ANGLE_W-1:0]          rsp_angle_a,
   input logic [tmu_pkg::ANGLE_W-1:0]          rsp_angle_b,
   input logic [tmu_pkg::ANGLE_W-1:0]          rsp_angle_c,
   input logic signed [tmu_pkg::COORD_W-1:0]   rsp_centroid_x,
   input logic signed [tmu_pkg::COORD_W-1:0]   rsp_centroid_y
);

   localparam logic [tmu_pkg::ANGLE_W-1:0] ANGLE_MAX = 16'd51472;

   // a held response must stay valid and keep its area, perimeter, angle a and centroid x
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_area)
         && $stable(rsp_perimeter) && $stable(rsp_angle_a) && $stable(rsp_centroid_x))
      else $error("held response changed");

   // the pipeline freezes while the response is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while response stalled");

   // no response in the cycle after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // angles never pass pi
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_a <= ANGLE_MAX && rsp_angle_b <= ANGLE_MAX
         && rsp_angle_c <= ANGLE_MAX)
      else $error("angle above pi");

endmodule

bind triangle_metrics_unit tmu_checker u_tmu_checker (.*);
